@@ rtl/water_ripple_field_engine_core_macros.svh @@
// ----------------------------------------------------------------------------
// Water ripple field engine assertion macros
// Short forms for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef WATER_RIPPLE_FIELD_ENGINE_CORE_MACROS_SVH
`define WATER_RIPPLE_FIELD_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, checked while reset is released.
`define WRFE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> cons) else $error(msg);

// Next-cycle implication, checked while reset is released.
`define WRFE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> cons) else $error(msg);

`endif

@@ rtl/wrfe_pkg.sv @@
// ----------------------------------------------------------------------------
// Water ripple field engine package
// Field geometry, field widths and operation codes shared by the RTL.
// ----------------------------------------------------------------------------
package wrfe_pkg;

  // Field geometry. Memory rows are padded to a power of two columns.
  localparam int FIELD_WIDTH  = 128;
  localparam int FIELD_HEIGHT = 64;
  localparam int COL_BITS     = $clog2(FIELD_WIDTH);
  localparam int ROW_BITS     = $clog2(FIELD_HEIGHT);
  localparam int ADDR_BITS    = COL_BITS + ROW_BITS;
  localparam int MEM_DEPTH    = FIELD_HEIGHT * (2 ** COL_BITS);
  localparam int LINE_DEPTH   = 2 ** COL_BITS;

  // Item field widths.
  localparam int OPCODE_W = 2;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 6;
  localparam int HEIGHT_W = 16;
  localparam int BRIGHT_W = 8;

  // Arithmetic.
  localparam int SUM_W      = HEIGHT_W + 2;
  localparam int COORD_W    = 12;
  localparam int DAMP_SHIFT = 5;
  localparam int BRIGHT_MAX = 255;

  typedef enum logic [OPCODE_W-1:0] {
    OP_DROP = 2'd0,
    OP_STEP = 2'd1,
    OP_READ = 2'd2
  } opcode_e;

endpackage

@@ rtl/wrfe_in_if.sv @@
// ----------------------------------------------------------------------------
// Water ripple field engine request channel
// Valid/ready channel that carries one command item.
// ----------------------------------------------------------------------------
interface wrfe_in_if import wrfe_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic [COL_W-1:0]           col;
  logic [ROW_W-1:0]           row;
  logic signed [HEIGHT_W-1:0] force_value;

  modport source (output valid, output opcode, output col, output row,
                  output force_value, input ready);
  modport sink   (input valid, input opcode, input col, input row,
                  input force_value, output ready);
endinterface

@@ rtl/wrfe_out_if.sv @@
// ----------------------------------------------------------------------------
// Water ripple field engine response channel
// Valid/ready channel that carries one read result item.
// ----------------------------------------------------------------------------
interface wrfe_out_if import wrfe_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [HEIGHT_W-1:0] height;
  logic [BRIGHT_W-1:0]        brightness;

  modport source (output valid, output height, output brightness, input ready);
  modport sink   (input valid, input height, input brightness, output ready);
endinterface

@@ rtl/water_ripple_field_engine_core.sv @@
// ----------------------------------------------------------------------------
// Water ripple field engine core
// Two-buffer height-field ripple simulation with drop, step and read items.
// ----------------------------------------------------------------------------
// The engine keeps two 128 x 64 fields of signed 16-bit heights in two
// single-port-read RAMs; one holds the newest (current) field and the other
// the previous one, and a select bit swaps their roles after every step.
// After reset the engine runs a clearing pass over all 8192 addresses that
// zeroes both RAMs; no item is accepted until it ends. A drop item writes its
// force into the interior cells of the 3x3 block around (col, row), one cell
// per cycle. A read item issues its RAM read when it is accepted and
// then waits only as long as a previous result still sits in the output
// register. A step item streams the current field out of its RAM in raster
// order, one cell per cycle, through two one-row line buffers, so the four
// neighbors of a cell are all at hand when the cell one row below and one
// column to the right arrives.
// The previous field is read and rewritten at the same pace through a short
// pipeline; the single read port of the current field sets the rate.
// The engine handles one item at a time and takes no new item while one is
// at work, but a waiting result never blocks drops and steps.
// ----------------------------------------------------------------------------
module water_ripple_field_engine_core import wrfe_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  wrfe_in_if.sink    req_i,
  wrfe_out_if.source rsp_o
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_DROP  = 6'b000100,
    ST_STEP  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_READ  = 6'b100000
  } state_e;

  // Control state.
  state_e               state_q, state_d;
  logic                 sel_q, sel_d;
  logic [ADDR_BITS-1:0] clr_addr_q, clr_addr_d;

  // Drop item.
  logic [COL_W-1:0]           drop_col_q, drop_col_d;
  logic [ROW_W-1:0]           drop_row_q, drop_row_d;
  logic signed [HEIGHT_W-1:0] drop_force_q, drop_force_d;
  logic [1:0]                 ddx_q, ddx_d;
  logic [1:0]                 ddy_q, ddy_d;
  logic [COORD_W-1:0]         x_p1, y_p1, x_cell, y_cell;
  logic                       drop_inside;

  // Read item.
  logic rd_oob_q, rd_oob_d;

  // Step stream position and center position.
  logic [ROW_BITS-1:0] s_row_q, s_row_d;
  logic [COL_BITS-1:0] s_col_q, s_col_d;
  logic [ROW_BITS-1:0] c_row_q, c_row_d;
  logic [COL_BITS-1:0] c_col_q, c_col_d;
  logic                ctr_run_q, ctr_run_d;
  logic                ctr_active;
  logic                c_inside;
  logic                issue;

  // Step pipeline.
  logic                       v1_q, i1_q;
  logic [ADDR_BITS-1:0]       a1_q;
  logic [COL_BITS-1:0]        lb_waddr_q;
  logic signed [HEIGHT_W-1:0] bot_q, mid1_q, mid2_q, top_q;
  logic                       v2_q;
  logic [ADDR_BITS-1:0]       a2_q;
  logic signed [HEIGHT_W-1:0] t2_q;
  logic signed [SUM_W-1:0]    nbr_sum;
  logic signed [SUM_W-2:0]    nbr_half;
  logic signed [SUM_W-2:0]    diff;
  logic signed [HEIGHT_W-1:0] damped;

  // Output register.
  logic                       out_valid_q, out_valid_d;
  logic signed [HEIGHT_W-1:0] out_height_q, out_height_d;
  logic [BRIGHT_W-1:0]        out_bright_q, out_bright_d;
  logic                       out_load;
  logic signed [HEIGHT_W-1:0] rd_height;
  logic [HEIGHT_W:0]          rd_mag;

  // Logical ports of the current and previous field, and the clearing port.
  logic                 cur_we, cur_re, prv_we, prv_re, clr_we;
  logic [ADDR_BITS-1:0] cur_waddr, cur_raddr, prv_waddr, prv_raddr;
  logic [HEIGHT_W-1:0]  cur_wdata, prv_wdata;
  logic [HEIGHT_W-1:0]  cur_rdata, prv_rdata;

  // Physical RAM ports.
  logic                 a_we, a_re, b_we, b_re;
  logic [ADDR_BITS-1:0] a_waddr, a_raddr, b_waddr, b_raddr;
  logic [HEIGHT_W-1:0]  a_wdata, b_wdata, a_rdata, b_rdata;
  logic [HEIGHT_W-1:0]  lb1_rdata, lb2_rdata;

  logic in_acc;

  assign req_i.ready = (state_q == ST_IDLE);
  assign in_acc      = req_i.valid && req_i.ready;

  // Drop block cell. The coordinates are offset by one so that they never
  // go negative; a cell is interior when 1 <= x <= FIELD_WIDTH-2.
  assign x_p1   = COORD_W'(drop_col_q) + COORD_W'(ddx_q);
  assign y_p1   = COORD_W'(drop_row_q) + COORD_W'(ddy_q);
  assign x_cell = x_p1 - COORD_W'(1);
  assign y_cell = y_p1 - COORD_W'(1);
  assign drop_inside = (x_p1 > COORD_W'(1)) && (x_p1 < COORD_W'(FIELD_WIDTH)) &&
                       (y_p1 > COORD_W'(1)) && (y_p1 < COORD_W'(FIELD_HEIGHT));

  // The center trails the stream by one row and one cell. It starts moving
  // when the stream reaches row 1, column 1.
  assign ctr_active = ctr_run_q || ((s_row_q == ROW_BITS'(1)) && (s_col_q == COL_BITS'(1)));
  assign c_inside   = (c_row_q != '0) && (c_row_q != ROW_BITS'(FIELD_HEIGHT - 1)) &&
                      (c_col_q != '0) && (c_col_q != COL_BITS'(FIELD_WIDTH - 1));
  assign issue      = (state_q == ST_STEP);

  // Stage A: neighbors N, S, W and E of the center, and the previous value.
  always_comb begin
    nbr_sum  = SUM_W'(top_q) + SUM_W'(bot_q) + SUM_W'(mid2_q) + SUM_W'($signed(lb1_rdata));
    nbr_half = nbr_sum[SUM_W-1:1];
    diff     = nbr_half - (SUM_W - 1)'($signed(prv_rdata));
  end

  // Stage B: damping by 1/32, rounded toward minus infinity, wrapping.
  assign damped = t2_q - (t2_q >>> DAMP_SHIFT);

  // Read result formatting.
  always_comb begin
    rd_height = rd_oob_q ? '0 : $signed(cur_rdata);
    rd_mag    = rd_height[HEIGHT_W-1] ? ((HEIGHT_W + 1)'(0) - {rd_height[HEIGHT_W-1], rd_height})
                                      : {1'b0, rd_height};
  end

  // Main sequencer.
  always_comb begin
    state_d      = state_q;
    sel_d        = sel_q;
    clr_addr_d   = clr_addr_q;
    drop_col_d   = drop_col_q;
    drop_row_d   = drop_row_q;
    drop_force_d = drop_force_q;
    ddx_d        = ddx_q;
    ddy_d        = ddy_q;
    rd_oob_d     = rd_oob_q;
    s_row_d      = s_row_q;
    s_col_d      = s_col_q;
    c_row_d      = c_row_q;
    c_col_d      = c_col_q;
    ctr_run_d    = ctr_run_q;
    out_load     = 1'b0;

    clr_we    = 1'b0;
    cur_we    = 1'b0;
    cur_waddr = {y_cell[ROW_BITS-1:0], x_cell[COL_BITS-1:0]};
    cur_wdata = drop_force_q;
    cur_re    = 1'b0;
    cur_raddr = {s_row_q, s_col_q};
    prv_re    = 1'b0;
    prv_raddr = {c_row_q, c_col_q};

    case (state_q)
      ST_CLEAR: begin
        clr_we     = 1'b1;
        clr_addr_d = clr_addr_q + ADDR_BITS'(1);
        if (clr_addr_q == ADDR_BITS'(MEM_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (opcode_e'(req_i.opcode))
            OP_DROP: begin
              drop_col_d   = req_i.col;
              drop_row_d   = req_i.row;
              drop_force_d = req_i.force_value;
              ddx_d        = '0;
              ddy_d        = '0;
              state_d      = ST_DROP;
            end
            OP_STEP: begin
              s_row_d   = '0;
              s_col_d   = '0;
              c_row_d   = '0;
              c_col_d   = '0;
              ctr_run_d = 1'b0;
              state_d   = ST_STEP;
            end
            OP_READ: begin
              // Issue the read at once; the data is back next cycle.
              cur_re    = 1'b1;
              cur_raddr = {ROW_BITS'(req_i.row), COL_BITS'(req_i.col)};
              rd_oob_d  = (COORD_W'(req_i.col) >= COORD_W'(FIELD_WIDTH)) ||
                          (COORD_W'(req_i.row) >= COORD_W'(FIELD_HEIGHT));
              state_d   = ST_READ;
            end
            default: begin
              // Unused opcode: the item is taken and dropped.
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_DROP: begin
        cur_we = drop_inside;
        if (ddx_q == 2'd2) begin
          ddx_d = '0;
          ddy_d = ddy_q + 2'd1;
          if (ddy_q == 2'd2) begin
            state_d = ST_IDLE;
          end
        end else begin
          ddx_d = ddx_q + 2'd1;
        end
      end
      ST_STEP: begin
        cur_re = 1'b1;
        prv_re = ctr_active;
        if (s_col_q == COL_BITS'(FIELD_WIDTH - 1)) begin
          s_col_d = '0;
          s_row_d = s_row_q + ROW_BITS'(1);
          if (s_row_q == ROW_BITS'(FIELD_HEIGHT - 1)) begin
            state_d = ST_DRAIN;
          end
        end else begin
          s_col_d = s_col_q + COL_BITS'(1);
        end
        if (ctr_active) begin
          ctr_run_d = 1'b1;
          if (c_col_q == COL_BITS'(FIELD_WIDTH - 1)) begin
            c_col_d = '0;
            c_row_d = c_row_q + ROW_BITS'(1);
          end else begin
            c_col_d = c_col_q + COL_BITS'(1);
          end
        end
      end
      ST_DRAIN: begin
        // Swap the fields once the last write has gone in.
        if (!v1_q && !v2_q) begin
          sel_d   = ~sel_q;
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Previous field is only written back from the step pipeline.
  assign prv_we    = v2_q;
  assign prv_waddr = a2_q;
  assign prv_wdata = damped;

  // Output register.
  always_comb begin
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_height_d = out_height_q;
    out_bright_d = out_bright_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_height_d = rd_height;
      out_bright_d = (rd_mag > (HEIGHT_W + 1)'(BRIGHT_MAX)) ? BRIGHT_W'(BRIGHT_MAX)
                                                            : rd_mag[BRIGHT_W-1:0];
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.height     = out_height_q;
  assign rsp_o.brightness = out_bright_q;

  // Map the current and previous ports onto the two RAMs. Field A is
  // current while the select bit is low.
  always_comb begin
    a_we    = clr_we || (sel_q ? prv_we : cur_we);
    a_waddr = clr_we ? clr_addr_q : (sel_q ? prv_waddr : cur_waddr);
    a_wdata = clr_we ? '0 : (sel_q ? prv_wdata : cur_wdata);
    a_re    = sel_q ? prv_re : cur_re;
    a_raddr = sel_q ? prv_raddr : cur_raddr;
    b_we    = clr_we || (sel_q ? cur_we : prv_we);
    b_waddr = clr_we ? clr_addr_q : (sel_q ? cur_waddr : prv_waddr);
    b_wdata = clr_we ? '0 : (sel_q ? cur_wdata : prv_wdata);
    b_re    = sel_q ? cur_re : prv_re;
    b_raddr = sel_q ? cur_raddr : prv_raddr;
  end

  assign cur_rdata = sel_q ? b_rdata : a_rdata;
  assign prv_rdata = sel_q ? a_rdata : b_rdata;

  wrfe_ram #(.Width(HEIGHT_W), .Depth(MEM_DEPTH)) u_field_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (a_wdata),
    .re_i    (a_re),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  wrfe_ram #(.Width(HEIGHT_W), .Depth(MEM_DEPTH)) u_field_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .re_i    (b_re),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // Line buffers: the first delays the stream by one row, the second by two.
  // Each is read at the column being issued and written in the next cycle at
  // the same column, so a read always returns the value from a row earlier.
  wrfe_ram #(.Width(HEIGHT_W), .Depth(LINE_DEPTH)) u_line_1 (
    .clk_i   (clk_i),
    .we_i    (v1_q),
    .waddr_i (lb_waddr_q),
    .wdata_i (cur_rdata),
    .re_i    (issue),
    .raddr_i (s_col_q),
    .rdata_o (lb1_rdata)
  );

  wrfe_ram #(.Width(HEIGHT_W), .Depth(LINE_DEPTH)) u_line_2 (
    .clk_i   (clk_i),
    .we_i    (v1_q),
    .waddr_i (lb_waddr_q),
    .wdata_i (lb1_rdata),
    .re_i    (issue),
    .raddr_i (s_col_q),
    .rdata_o (lb2_rdata)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      sel_q       <= 1'b0;
      clr_addr_q  <= '0;
      ddx_q       <= '0;
      ddy_q       <= '0;
      s_row_q     <= '0;
      s_col_q     <= '0;
      c_row_q     <= '0;
      c_col_q     <= '0;
      ctr_run_q   <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      clr_addr_q  <= clr_addr_d;
      ddx_q       <= ddx_d;
      ddy_q       <= ddy_d;
      s_row_q     <= s_row_d;
      s_col_q     <= s_col_d;
      c_row_q     <= c_row_d;
      c_col_q     <= c_col_d;
      ctr_run_q   <= ctr_run_d;
      v1_q        <= issue;
      v2_q        <= v1_q && i1_q;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    drop_col_q   <= drop_col_d;
    drop_row_q   <= drop_row_d;
    drop_force_q <= drop_force_d;
    rd_oob_q     <= rd_oob_d;
    out_height_q <= out_height_d;
    out_bright_q <= out_bright_d;
    i1_q         <= ctr_active && c_inside;
    a1_q         <= {c_row_q, c_col_q};
    lb_waddr_q   <= s_col_q;
    a2_q         <= a1_q;
    t2_q         <= diff[HEIGHT_W-1:0];
    if (v1_q) begin
      bot_q  <= $signed(cur_rdata);
      mid1_q <= $signed(lb1_rdata);
      mid2_q <= mid1_q;
      top_q  <= $signed(lb2_rdata);
    end
  end

endmodule

@@ rtl/wrfe_ram.sv @@
// ----------------------------------------------------------------------------
// Water ripple field engine RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module wrfe_ram #(
  parameter int  Width = 16,
  parameter int  Depth = 256,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/wrfe_checker.sv @@
// ----------------------------------------------------------------------------
// Water ripple field engine port checker
// Concurrent assertions on the request and response ports of the core.
// ----------------------------------------------------------------------------
`include "water_ripple_field_engine_core_macros.svh"

module wrfe_checker import wrfe_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic [OPCODE_W-1:0]        in_opcode_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic signed [HEIGHT_W-1:0] rsp_height_i,
  input logic [BRIGHT_W-1:0]        rsp_brightness_i
);

  logic in_acc;
  logic is_read, is_work;
  logic big;
  logic [HEIGHT_W-1:0] abs_height;

  assign in_acc  = in_valid_i && in_ready_i;
  assign is_read = (in_opcode_i == OP_READ);
  assign is_work = (in_opcode_i == OP_DROP) || (in_opcode_i == OP_STEP);

  // Magnitude check written as a range test rather than a clamp.
  assign big        = (rsp_height_i > 16'sd255) || (rsp_height_i < -16'sd255);
  assign abs_height = (rsp_height_i < 0) ? HEIGHT_W'(-rsp_height_i) : rsp_height_i;

  `WRFE_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i, "result item dropped while stalled")
  `WRFE_ASSERT_NEXT(a_rsp_stable, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, $stable(rsp_height_i) && $stable(rsp_brightness_i), "result item changed while stalled")
  `WRFE_ASSERT_NOW(a_bright, clk_i, rst_ni, rsp_valid_i, (big ? (rsp_brightness_i == 8'd255) : (rsp_brightness_i == abs_height[BRIGHT_W-1:0])), "brightness does not match height")
  `WRFE_ASSERT_NEXT(a_busy, clk_i, rst_ni, in_acc && is_work, !in_ready_i, "engine ready right after a drop or step")
  `WRFE_ASSERT_NOW(a_read_lat, clk_i, rst_ni, in_acc && is_read && !rsp_valid_i, ##2 rsp_valid_i, "read result late")

endmodule

bind water_ripple_field_engine_core wrfe_checker u_wrfe_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (req_i.valid),
  .in_ready_i       (req_i.ready),
  .in_opcode_i      (req_i.opcode),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_height_i     (rsp_o.height),
  .rsp_brightness_i (rsp_o.brightness)
);

@@ tb/water_ripple_field_engine_core_checker.sv @@
// ----------------------------------------------------------------------------
// Water ripple field engine checker
// Watches both channels, predicts every read result from its own copy of the
// two height fields, and compares the results in order.
// ----------------------------------------------------------------------------
module water_ripple_field_engine_core_checker import wrfe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  wrfe_in_if   req_i,
  wrfe_out_if  rsp_i,
  output int   mismatches_o,
  output int   pending_o
);

  typedef struct packed {
    logic signed [HEIGHT_W-1:0] height;
    logic [BRIGHT_W-1:0]        brightness;
  } read_result_t;

  // Both height fields; the index newest_sel picks the newest one.
  logic signed [HEIGHT_W-1:0] heights [2][FIELD_HEIGHT][FIELD_WIDTH];
  bit                         newest_sel;
  read_result_t               pending_reads [$];
  int                         mismatch_total;

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatch_total++;
  endtask

  // Writes the interior cells of the 3x3 block around (c, r).
  task automatic apply_drop(input int c, input int r, input logic signed [HEIGHT_W-1:0] level);
    int x;
    int y;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        x = c + dx;
        y = r + dy;
        if (x > 0 && x < FIELD_WIDTH - 1 && y > 0 && y < FIELD_HEIGHT - 1) begin
          heights[newest_sel][y][x] = level;
        end
      end
    end
  endtask

  // One ripple step: the older field is rebuilt from the newest, then the
  // two swap roles.
  task automatic advance_ripple();
    bit                         older_sel;
    int                         sum;
    int                         damped;
    logic signed [HEIGHT_W-1:0] wave;
    older_sel = ~newest_sel;
    for (int y = 1; y < FIELD_HEIGHT - 1; y++) begin
      for (int x = 1; x < FIELD_WIDTH - 1; x++) begin
        sum = int'(heights[newest_sel][y][x-1]) + int'(heights[newest_sel][y][x+1])
            + int'(heights[newest_sel][y-1][x]) + int'(heights[newest_sel][y+1][x]);
        wave = HEIGHT_W'((sum >>> 1) - int'(heights[older_sel][y][x]));
        damped = int'(wave) - (int'(wave) >>> DAMP_SHIFT);
        heights[older_sel][y][x] = HEIGHT_W'(damped);
      end
    end
    newest_sel = older_sel;
  endtask

  function automatic read_result_t read_cell(input int c, input int r);
    read_result_t res;
    int           mag;
    res.height = '0;
    if (c < FIELD_WIDTH && r < FIELD_HEIGHT) begin
      res.height = heights[newest_sel][r][c];
    end
    mag = (res.height < 0) ? -int'(res.height) : int'(res.height);
    res.brightness = BRIGHT_W'((mag > BRIGHT_MAX) ? BRIGHT_MAX : mag);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    read_result_t want;
    if (!rst_ni) begin
      foreach (heights[f, y, x]) heights[f][y][x] = '0;
      newest_sel = 1'b0;
      pending_reads.delete();
      mismatch_total = 0;
    end else begin
      // Results first: a read accepted at this edge cannot answer now.
      if (rsp_i.valid && rsp_i.ready) begin
        if (pending_reads.size() == 0) begin
          report($sformatf("unexpected result, height %0d brightness %0d",
                           rsp_i.height, rsp_i.brightness));
        end else begin
          want = pending_reads.pop_front();
          if (rsp_i.height !== want.height) begin
            report($sformatf("height %0d, expected %0d", rsp_i.height, want.height));
          end
          if (rsp_i.brightness !== want.brightness) begin
            report($sformatf("brightness %0d, expected %0d",
                             rsp_i.brightness, want.brightness));
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        case (opcode_e'(req_i.opcode))
          OP_DROP: apply_drop(int'(req_i.col), int'(req_i.row), req_i.force_value);
          OP_STEP: advance_ripple();
          OP_READ: pending_reads.push_back(read_cell(int'(req_i.col), int'(req_i.row)));
          default: ;
        endcase
      end
    end
    mismatches_o <= mismatch_total;
    pending_o    <= pending_reads.size();
  end

endmodule

@@ tb/water_ripple_field_engine_core_tb.sv @@
// ----------------------------------------------------------------------------
// Water ripple field engine testbench
// Drives drop, step and read items into the engine under random idling on
// both channels; a checker beside the engine predicts and compares results.
// ----------------------------------------------------------------------------
module water_ripple_field_engine_core_tb;
  import wrfe_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 10;
  // A step streams 8192 cells with nothing accepted, and so does the
  // clearing pass after reset; the limit leaves several times that margin.
  localparam int QUIET_LIMIT  = 40000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_ITEMS = 80;

  // The one opcode the engine must ignore.
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int tx_idle_pct = 11;
  int rx_idle_pct = 85;
  int quiet_cycles = 0;
  int mismatches;
  int pending;

  wrfe_in_if  req_if ();
  wrfe_out_if rsp_if ();

  water_ripple_field_engine_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  water_ripple_field_engine_core_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always #HALF_PERIOD clk = ~clk;

  // The result side drops ready at random, at the rate of the current phase.
  always @(posedge clk) begin
    rsp_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // The watchdog only counts cycles in which neither channel moves an item,
  // so a long run of steps never trips it while the engine makes progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", quiet_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Offers one item and returns at the edge where the engine accepts it.
  // Random idle cycles come before the item, never between a lowered and a
  // raised valid in the same step, so back-to-back items keep valid high.
  task automatic send_item(input logic [OPCODE_W-1:0] op, input int c, input int r,
                           input int level);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.opcode      <= op;
    req_if.col         <= COL_W'(c);
    req_if.row         <= ROW_W'(r);
    req_if.force_value <= HEIGHT_W'(level);
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  initial begin
    int counted;
    int pick;
    int c;
    int r;
    int level;
    int last_c;
    int last_r;

    // The request side starts idle at a known value before the first edge.
    req_if.valid       = 1'b0;
    req_if.opcode      = '0;
    req_if.col         = '0;
    req_if.row         = '0;
    req_if.force_value = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A cleared field reads zero everywhere, the corners too.
    send_item(OP_READ, 0, 0, 0);
    send_item(OP_READ, FIELD_WIDTH - 1, FIELD_HEIGHT - 1, 0);
    // A full-height drop in the middle, read at its center and corners.
    send_item(OP_DROP, 64, 32, 32767);
    send_item(OP_READ, 64, 32, 0);
    send_item(OP_READ, 63, 31, 0);
    send_item(OP_READ, 65, 33, 0);
    // A drop on a corner only reaches the single interior cell next to it,
    // and the most negative height must still read as full brightness.
    send_item(OP_DROP, 0, 0, -32768);
    send_item(OP_READ, 1, 1, 0);
    send_item(OP_READ, 0, 0, 0);
    send_item(OP_DROP, FIELD_WIDTH - 1, FIELD_HEIGHT - 1, 300);
    send_item(OP_READ, FIELD_WIDTH - 2, FIELD_HEIGHT - 2, 0);
    send_item(OP_READ, FIELD_WIDTH - 1, FIELD_HEIGHT - 1, 0);
    send_item(OP_DROP, 1, FIELD_HEIGHT - 2, -1);
    // The unused opcode must change nothing and return nothing.
    send_item(OP_UNUSED, 64, 32, 12345);
    send_item(OP_READ, 64, 32, 0);
    // Two steps spread the drops out; reads look at the ripple around them.
    send_item(OP_STEP, 0, 0, 0);
    send_item(OP_READ, 64, 32, 0);
    send_item(OP_READ, 64, 30, 0);
    send_item(OP_READ, 2, 2, 0);
    send_item(OP_STEP, 0, 0, 0);
    send_item(OP_READ, 64, 33, 0);
    send_item(OP_DROP, FIELD_WIDTH - 2, 1, 21845);
    send_item(OP_READ, FIELD_WIDTH - 2, 1, 0);

    // Random part in three idling phases. Reads cluster around the last
    // drop so that steps are seen shaping the ripple, not just zeros.
    counted = 0;
    last_c  = 64;
    last_r  = 32;
    while (counted < RANDOM_ITEMS) begin
      if (counted < RANDOM_ITEMS / 3) begin
        tx_idle_pct = 11;
        rx_idle_pct = 85;
      end else if (counted < 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 85;
        rx_idle_pct = 11;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 24) begin
        c = $urandom_range(0, FIELD_WIDTH - 1);
        r = $urandom_range(0, FIELD_HEIGHT - 1);
        // Half the drops stay small so brightness is seen below its clamp.
        if ($urandom_range(0, 1) == 0) begin
          level = int'($urandom_range(0, 600)) - 300;
        end else begin
          level = int'($urandom);
        end
        last_c = c;
        last_r = r;
        send_item(OP_DROP, c, r, level);
        counted++;
      end else if (pick < 36) begin
        send_item(OP_STEP, $urandom_range(0, FIELD_WIDTH - 1),
                  $urandom_range(0, FIELD_HEIGHT - 1), int'($urandom));
        counted++;
      end else if (pick < 95) begin
        if ($urandom_range(0, 99) < 65) begin
          c = last_c + int'($urandom_range(0, 6)) - 3;
          r = last_r + int'($urandom_range(0, 6)) - 3;
          c = (c < 0) ? 0 : ((c > FIELD_WIDTH - 1) ? FIELD_WIDTH - 1 : c);
          r = (r < 0) ? 0 : ((r > FIELD_HEIGHT - 1) ? FIELD_HEIGHT - 1 : r);
        end else begin
          c = $urandom_range(0, FIELD_WIDTH - 1);
          r = $urandom_range(0, FIELD_HEIGHT - 1);
        end
        send_item(OP_READ, c, r, int'($urandom));
        counted++;
      end else begin
        // Noise that the engine ignores; it does not count as an item.
        send_item(OP_UNUSED, $urandom_range(0, FIELD_WIDTH - 1),
                  $urandom_range(0, FIELD_HEIGHT - 1), int'($urandom));
      end
    end
    req_if.valid <= 1'b0;

    // Wait for every predicted read, then a little longer to catch any
    // stray result; the watchdog bounds both waits.
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
